// File: design/sicr_pkg.sv
// Shared types, constants and helpers for the sea ice concentration pipeline.
package sicr_pkg;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_FLOOR   = 2'd1,
        ST_WEATHER = 2'd2,
        ST_RANGE   = 2'd3
    } sicr_status_t;

    typedef enum logic [2:0] {
        REG_FLOORS   = 3'd0,
        REG_WLIM     = 3'd1,
        REG_COEF_0_1 = 3'd2,
        REG_COEF_2_3 = 3'd3,
        REG_COEF_4_5 = 3'd4,
        REG_COEF_6_7 = 3'd5,
        REG_COEF_8_9 = 3'd6,
        REG_COEF_A_B = 3'd7
    } sicr_reg_idx_t;

    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int FLOOR_W   = 16;
    localparam int NUM_COEF  = 12;
    localparam int NUM_PAIRS = 6;
    localparam int COEF_W    = 32;
    localparam int Q_BITS    = 16;
    localparam int Q_FRAC    = 15;
    localparam int PROD_W    = 48;
    localparam int SUM_W     = PROD_W + 1;
    localparam int FORM_W    = PROD_W + 2;
    localparam int NUM_W     = FORM_W + 1;
    localparam int PCT_W     = 62;
    localparam int PCT_QBITS = 8;
    localparam int TOT_W     = 10;

    localparam logic [15:0] WLIM_RESET = 16'd1638;
    localparam logic [15:0] Q15_MAX    = 16'h7FFF;
    localparam logic [31:0] ROUND_HALF = 32'd16384;

    // percent is carried with a bias of 20 so the quotient is never negative
    localparam logic [PCT_QBITS-1:0]  Q_LIMIT  = 8'd140;
    localparam logic signed [TOT_W-1:0] TOT_BIAS = 10'sd40;
    localparam logic signed [TOT_W-1:0] TOT_LO   = -10'sd20;
    localparam logic signed [TOT_W-1:0] TOT_HI   = 10'sd120;
    localparam logic signed [TOT_W-1:0] TOT_MAX  = 10'sd100;
    localparam logic [6:0] CONC_MAX = 7'd100;

    typedef struct packed {
        logic [47:0]                       floors;
        logic signed [15:0]                wlim;
        logic [NUM_COEF-1:0][COEF_W-1:0]   coef;
    } sicr_cfg_t;

    typedef struct packed {
        sicr_status_t st;
        logic         eoi;
    } sicr_side_t;

    // sign a Q1.15 magnitude, saturating only a positive result
    function automatic logic signed [15:0] q15_apply(input logic [15:0] mag, input logic neg);
        logic [15:0] lim;
        lim = (mag > Q15_MAX) ? Q15_MAX : mag;
        return neg ? -$signed(mag) : $signed(lim);
    endfunction

endpackage

// File: design/sicr_regs.sv
// APB configuration registers: floors, weather limit and the twelve coefficients.
module sicr_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sicr_pkg::ADDR_W-1:0]   paddr,
    input  logic [sicr_pkg::DATA_W-1:0]   pwdata,
    output logic [sicr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output sicr_pkg::sicr_cfg_t           cfg
);
    import sicr_pkg::*;

    logic [47:0]        floors_reg;
    logic [15:0]        wlim_reg;
    logic [DATA_W-1:0]  coef_reg [NUM_PAIRS];
    sicr_reg_idx_t      idx;
    logic [2:0]         cidx;
    logic               wr;

    assign idx    = sicr_reg_idx_t'(paddr[5:3]);
    assign cidx   = 3'(paddr[5:3] - 3'd2);
    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floors_reg <= '0;
            wlim_reg   <= WLIM_RESET;
            for (int k = 0; k < NUM_PAIRS; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (wr)
        begin
            case (idx)
                REG_FLOORS: floors_reg <= pwdata[47:0];
                REG_WLIM:   wlim_reg   <= pwdata[15:0];
                default:    coef_reg[cidx] <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FLOORS: prdata = {16'b0, floors_reg};
            REG_WLIM:   prdata = {48'b0, wlim_reg};
            default:    prdata = coef_reg[cidx];
        endcase
    end

    always_comb
    begin
        cfg.floors = floors_reg;
        cfg.wlim   = $signed(wlim_reg);
        for (int k = 0; k < NUM_PAIRS; k++)
        begin
            cfg.coef[2*k]   = coef_reg[k][31:0];
            cfg.coef[2*k+1] = coef_reg[k][63:32];
        end
    end

    a_wlim_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr && (idx == REG_WLIM) |=> wlim_reg == $past(pwdata[15:0]))
        else $error("weather limit write lost");

endmodule

// File: design/sicr_ratio.sv
// Floor check and pipelined radix-2 division of the gradient and polarization ratios.
module sicr_ratio #(
    parameter int TB_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      vld,
    input  logic [TB_BITS-1:0]        v19,
    input  logic [TB_BITS-1:0]        h19,
    input  logic [TB_BITS-1:0]        v37,
    input  logic                      eoi,
    input  logic [47:0]               floors,
    input  logic signed [15:0]        wlim,
    output logic                      rat_vld,
    output logic signed [15:0]        gr,
    output logic signed [15:0]        pr,
    output sicr_pkg::sicr_side_t      rat_side
);
    import sicr_pkg::*;

    localparam int CW  = (TB_BITS > FLOOR_W) ? TB_BITS : FLOOR_W;
    localparam int YW  = TB_BITS + 2;
    localparam int DW  = TB_BITS + Q_BITS + 1;
    localparam int NST = Q_BITS;

    // lane 0: gradient ratio, lane 1: polarization ratio
    logic [TB_BITS-1:0] la [2];
    logic [TB_BITS-1:0] lb [2];
    logic               neg_c [2];
    logic [TB_BITS-1:0] mag_c [2];
    logic [TB_BITS:0]   sum_c [2];
    logic               flr_c;

    logic [DW-1:0]      rem_reg [0:NST-1][2];
    logic [YW-1:0]      y_reg   [0:NST-1][2];
    logic [Q_BITS-1:0]  q_reg   [1:NST][2];
    logic               neg_reg [0:NST][2];
    logic               flr_reg [0:NST];
    logic               eoi_reg [0:NST];
    logic               vld_reg [0:NST];

    logic signed [15:0] gr_c;
    logic signed [15:0] pr_c;
    logic signed [15:0] gr_reg;
    logic signed [15:0] pr_reg;
    sicr_side_t         side_reg;
    logic               out_vld_reg;

    assign la[0] = v37;
    assign lb[0] = v19;
    assign la[1] = v19;
    assign lb[1] = h19;

    assign flr_c = (CW'(v19) <= CW'(floors[15:0]))  ||
                   (CW'(h19) <= CW'(floors[31:16])) ||
                   (CW'(v37) <= CW'(floors[47:32]));

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            neg_c[l] = la[l] < lb[l];
            mag_c[l] = neg_c[l] ? (lb[l] - la[l]) : (la[l] - lb[l]);
            sum_c[l] = {1'b0, la[l]} + {1'b0, lb[l]};
        end
    end

    // round(mag*32768/sum) = floor((65536*mag + sum) / (2*sum))
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[0][l] <= (DW'(mag_c[l]) << Q_BITS) + DW'(sum_c[l]);
                y_reg[0][l]   <= {sum_c[l], 1'b0};
                neg_reg[0][l] <= neg_c[l];
            end
            flr_reg[0] <= flr_c;
            eoi_reg[0] <= eoi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= vld;
        end
    end

    for (genvar s = 1; s <= NST; s++)
    begin : g_st
        for (genvar l = 0; l < 2; l++)
        begin : g_ln
            logic [DW-1:0] ysh;
            logic          ge;

            assign ysh = DW'(y_reg[s-1][l]) << (NST - s);
            assign ge  = rem_reg[s-1][l] >= ysh;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    neg_reg[s][l] <= neg_reg[s-1][l];
                end
            end

            if (s < NST)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[s][l] <= ge ? (rem_reg[s-1][l] - ysh) : rem_reg[s-1][l];
                        y_reg[s][l]   <= y_reg[s-1][l];
                    end
                end
            end

            if (s == 1)
            begin : g_q0
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        q_reg[s][l] <= Q_BITS'(ge);
                    end
                end
            end
            else
            begin : g_qn
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        q_reg[s][l] <= {q_reg[s-1][l][Q_BITS-2:0], ge};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flr_reg[s] <= flr_reg[s-1];
                eoi_reg[s] <= eoi_reg[s-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    assign gr_c = q15_apply(q_reg[NST][0], neg_reg[NST][0]);
    assign pr_c = q15_apply(q_reg[NST][1], neg_reg[NST][1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gr_reg       <= gr_c;
            pr_reg       <= pr_c;
            side_reg.eoi <= eoi_reg[NST];
            if (flr_reg[NST])
            begin
                side_reg.st <= ST_FLOOR;
            end
            else if (gr_c > wlim)
            begin
                side_reg.st <= ST_WEATHER;
            end
            else
            begin
                side_reg.st <= ST_VALID;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[NST];
        end
    end

    assign gr       = gr_reg;
    assign pr       = pr_reg;
    assign rat_side = side_reg;
    assign rat_vld  = out_vld_reg;

    a_weather: assert property (@(posedge clk) disable iff (!rst_n)
        rat_vld && (rat_side.st == ST_WEATHER) |-> gr > wlim)
        else $error("weather status without ratio above limit");

endmodule

// File: design/sicr_forms.sv
// PR*GR product and the three bilinear forms, multiplies and adds on separate stages.
module sicr_forms (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              en,
    input  logic                                              rat_vld,
    input  logic signed [15:0]                                gr,
    input  logic signed [15:0]                                pr,
    input  sicr_pkg::sicr_side_t                              rat_side,
    input  logic [sicr_pkg::NUM_COEF-1:0][sicr_pkg::COEF_W-1:0] coef,
    output logic                                              frm_vld,
    output logic signed [sicr_pkg::FORM_W-1:0]                anf,
    output logic signed [sicr_pkg::FORM_W-1:0]                den,
    output logic signed [sicr_pkg::FORM_W-1:0]                anm,
    output sicr_pkg::sicr_side_t                              frm_side
);
    import sicr_pkg::*;

    logic signed [31:0]        p1_reg;
    logic signed [15:0]        gr1_reg;
    logic signed [15:0]        pr1_reg;
    logic signed [15:0]        gr2_reg;
    logic signed [15:0]        pr2_reg;
    logic signed [15:0]        prgr2_reg;
    logic signed [PROD_W-1:0]  t3_reg [NUM_COEF];
    logic signed [SUM_W-1:0]   s4_reg [NUM_COEF/2];
    logic signed [FORM_W-1:0]  f5_reg [3];
    sicr_side_t                side_reg [1:5];
    logic                      vld_reg  [1:5];

    logic [31:0]               mag2;
    logic [31:0]               rq2;

    assign mag2 = p1_reg[31] ? 32'(-p1_reg) : 32'(p1_reg);
    assign rq2  = (mag2 + ROUND_HALF) >> Q_FRAC;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= 32'(gr) * 32'(pr);
            gr1_reg   <= gr;
            pr1_reg   <= pr;

            gr2_reg   <= gr1_reg;
            pr2_reg   <= pr1_reg;
            prgr2_reg <= q15_apply(16'(rq2), p1_reg[31]);

            for (int f = 0; f < 3; f++)
            begin
                t3_reg[4*f]   <= PROD_W'($signed(coef[4*f])) <<< Q_FRAC;
                t3_reg[4*f+1] <= PROD_W'($signed(coef[4*f+1])) * PROD_W'(pr2_reg);
                t3_reg[4*f+2] <= PROD_W'($signed(coef[4*f+2])) * PROD_W'(gr2_reg);
                t3_reg[4*f+3] <= PROD_W'($signed(coef[4*f+3])) * PROD_W'(prgr2_reg);
            end

            for (int k = 0; k < NUM_COEF/2; k++)
            begin
                s4_reg[k] <= SUM_W'(t3_reg[2*k]) + SUM_W'(t3_reg[2*k+1]);
            end

            for (int f = 0; f < 3; f++)
            begin
                f5_reg[f] <= FORM_W'(s4_reg[2*f]) + FORM_W'(s4_reg[2*f+1]);
            end

            side_reg[1] <= rat_side;
            for (int s = 2; s <= 5; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= 5; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[1] <= rat_vld;
            for (int s = 2; s <= 5; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    assign anf      = f5_reg[0];
    assign den      = f5_reg[1];
    assign anm      = f5_reg[2];
    assign frm_side = side_reg[5];
    assign frm_vld  = vld_reg[5];

endmodule

// File: design/sicr_percent.sv
// Rounded first-year and multi-year percents: scaling, range screen, 8-step restoring division.
module sicr_percent (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   frm_vld,
    input  logic signed [sicr_pkg::FORM_W-1:0]     anf,
    input  logic signed [sicr_pkg::FORM_W-1:0]     den,
    input  logic signed [sicr_pkg::FORM_W-1:0]     anm,
    input  sicr_pkg::sicr_side_t                   frm_side,
    output logic                                   pct_vld,
    output logic [1:0][sicr_pkg::PCT_QBITS-1:0]    pct_q,
    output logic [1:0]                             pct_bad,
    output sicr_pkg::sicr_side_t                   pct_side
);
    import sicr_pkg::*;

    localparam int NQ   = PCT_QBITS;
    localparam int NPRE = 4;
    localparam int NALL = NPRE + NQ;

    logic                      dneg;
    logic signed [NUM_W-1:0]   n1_reg [2];
    logic signed [NUM_W-1:0]   d1_reg;
    logic signed [PCT_W-1:0]   a2_reg [2];
    logic signed [PCT_W-1:0]   b2_reg;
    logic signed [NUM_W-1:0]   d2_reg;
    logic signed [PCT_W-1:0]   np3_reg [2];
    logic signed [PCT_W-1:0]   dd3_reg;

    // index 0 is the range screen stage, then one quotient bit per stage
    logic signed [PCT_W-1:0]   rem_reg [0:NQ-1][2];
    logic signed [PCT_W-1:0]   dd_reg  [0:NQ-1];
    logic [NQ-1:0]             q_reg   [1:NQ][2];
    logic                      bad_reg [0:NQ][2];

    sicr_side_t                side_reg [1:NALL];
    logic                      vld_reg  [1:NALL];

    assign dneg = den[FORM_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // fold a negative denominator into the numerators
            n1_reg[0] <= dneg ? -NUM_W'(anf) : NUM_W'(anf);
            n1_reg[1] <= dneg ? -NUM_W'(anm) : NUM_W'(anm);
            d1_reg    <= dneg ? -NUM_W'(den) : NUM_W'(den);
            side_reg[1].eoi <= frm_side.eoi;
            side_reg[1].st  <= ((frm_side.st == ST_VALID) && (den == '0)) ?
                               ST_RANGE : frm_side.st;

            // 200*num and 41*den: the biased percent is (200*num + 41*den) / (2*den)
            for (int l = 0; l < 2; l++)
            begin
                a2_reg[l] <= (PCT_W'(n1_reg[l]) <<< 7) + (PCT_W'(n1_reg[l]) <<< 6) +
                             (PCT_W'(n1_reg[l]) <<< 3);
            end
            b2_reg <= (PCT_W'(d1_reg) <<< 5) + (PCT_W'(d1_reg) <<< 3) + PCT_W'(d1_reg);
            d2_reg <= d1_reg;

            for (int l = 0; l < 2; l++)
            begin
                np3_reg[l] <= a2_reg[l] + b2_reg;
            end
            dd3_reg <= PCT_W'(d2_reg) <<< 1;

            for (int l = 0; l < 2; l++)
            begin
                rem_reg[0][l] <= np3_reg[l];
                bad_reg[0][l] <= np3_reg[l][PCT_W-1] || (np3_reg[l] >= (dd3_reg <<< NQ));
            end
            dd_reg[0] <= dd3_reg;

            for (int s = 2; s <= NALL; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= NALL; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[1] <= frm_vld;
            for (int s = 2; s <= NALL; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    for (genvar s = 1; s <= NQ; s++)
    begin : g_st
        for (genvar l = 0; l < 2; l++)
        begin : g_ln
            logic signed [PCT_W-1:0] ysh;
            logic                    ge;

            assign ysh = dd_reg[s-1] <<< (NQ - s);
            assign ge  = rem_reg[s-1][l] >= ysh;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    bad_reg[s][l] <= bad_reg[s-1][l];
                end
            end

            if (s < NQ)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[s][l] <= ge ? (rem_reg[s-1][l] - ysh) : rem_reg[s-1][l];
                    end
                end
            end

            if (s == 1)
            begin : g_q0
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        q_reg[s][l] <= NQ'(ge);
                    end
                end
            end
            else
            begin : g_qn
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        q_reg[s][l] <= {q_reg[s-1][l][NQ-2:0], ge};
                    end
                end
            end
        end

        if (s < NQ)
        begin : g_dd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dd_reg[s] <= dd_reg[s-1];
                end
            end
        end
    end

    assign pct_q[0]   = q_reg[NQ][0];
    assign pct_q[1]   = q_reg[NQ][1];
    assign pct_bad[0] = bad_reg[NQ][0];
    assign pct_bad[1] = bad_reg[NQ][1];
    assign pct_side   = side_reg[NALL];
    assign pct_vld    = vld_reg[NALL];

endmodule

// File: design/sea_ice_concentration_ratio.sv
// Sea ice concentration top level: config port, ratio, form and percent pipeline, output word.
// One pixel word enters per clock unless pix_stall is high. It passes 18 stages of floor check
// and two radix-2 ratio dividers (one quotient bit per stage), 5 stages of PR*GR and the
// bilinear forms, 12 stages of percent scaling and 8-bit restoring division, and the output
// register. The pipeline advances as a whole; pix_stall rises only while a finished word sits
// stalled in the output register. Registers are 64 bits wide on the APB port at byte address
// 8*index and may be written only while the pipeline is empty.
module sea_ice_concentration_ratio #(
    parameter int TB_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  logic [TB_BITS-1:0]            tb_19v,
    input  logic [TB_BITS-1:0]            tb_19h,
    input  logic [TB_BITS-1:0]            tb_37v,
    input  logic                          end_of_image,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [6:0]                    concentration,
    output logic [1:0]                    status,
    output logic                          end_of_image_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sicr_pkg::ADDR_W-1:0]   paddr,
    input  logic [sicr_pkg::DATA_W-1:0]   pwdata,
    output logic [sicr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import sicr_pkg::*;

    sicr_cfg_t                 cfg;
    logic                      en;

    logic                      rat_vld;
    logic signed [15:0]        gr;
    logic signed [15:0]        pr;
    sicr_side_t                rat_side;

    logic                      frm_vld;
    logic signed [FORM_W-1:0]  anf;
    logic signed [FORM_W-1:0]  den;
    logic signed [FORM_W-1:0]  anm;
    sicr_side_t                frm_side;

    logic                      pct_vld;
    logic [1:0][PCT_QBITS-1:0] pct_q;
    logic [1:0]                pct_bad;
    sicr_side_t                pct_side;

    logic                      fy_ok;
    logic                      my_ok;
    logic signed [TOT_W-1:0]   tot;
    logic                      tot_ok;
    sicr_status_t              st_c;
    logic [6:0]                conc_c;

    logic                      vld_reg;
    logic [6:0]                conc_reg;
    sicr_status_t              st_reg;
    logic                      eoi_reg;

    assign en        = !vld_reg || !res_stall;
    assign pix_stall = !en;

    sicr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sicr_ratio #(
        .TB_BITS (TB_BITS)
    ) u_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld      (pix_valid),
        .v19      (tb_19v),
        .h19      (tb_19h),
        .v37      (tb_37v),
        .eoi      (end_of_image),
        .floors   (cfg.floors),
        .wlim     (cfg.wlim),
        .rat_vld  (rat_vld),
        .gr       (gr),
        .pr       (pr),
        .rat_side (rat_side)
    );

    sicr_forms u_forms (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .rat_vld  (rat_vld),
        .gr       (gr),
        .pr       (pr),
        .rat_side (rat_side),
        .coef     (cfg.coef),
        .frm_vld  (frm_vld),
        .anf      (anf),
        .den      (den),
        .anm      (anm),
        .frm_side (frm_side)
    );

    sicr_percent u_percent (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .frm_vld  (frm_vld),
        .anf      (anf),
        .den      (den),
        .anm      (anm),
        .frm_side (frm_side),
        .pct_vld  (pct_vld),
        .pct_q    (pct_q),
        .pct_bad  (pct_bad),
        .pct_side (pct_side)
    );

    // quotients carry a bias of 20
    assign fy_ok  = !pct_bad[0] && (pct_q[0] <= Q_LIMIT);
    assign my_ok  = !pct_bad[1] && (pct_q[1] <= Q_LIMIT);
    assign tot    = $signed({2'b00, pct_q[0]}) + $signed({2'b00, pct_q[1]}) - TOT_BIAS;
    assign tot_ok = (tot >= TOT_LO) && (tot <= TOT_HI);

    always_comb
    begin
        if (pct_side.st != ST_VALID)
        begin
            st_c = pct_side.st;
        end
        else if (fy_ok && my_ok && tot_ok)
        begin
            st_c = ST_VALID;
        end
        else
        begin
            st_c = ST_RANGE;
        end

        if (st_c != ST_VALID || tot[TOT_W-1])
        begin
            conc_c = '0;
        end
        else if (tot > TOT_MAX)
        begin
            conc_c = CONC_MAX;
        end
        else
        begin
            conc_c = tot[6:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            conc_reg <= conc_c;
            st_reg   <= st_c;
            eoi_reg  <= pct_side.eoi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= pct_vld;
        end
    end

    assign res_valid        = vld_reg;
    assign concentration    = conc_reg;
    assign status           = st_reg;
    assign end_of_image_out = eoi_reg;

    a_zero_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (st_reg != ST_VALID) |-> concentration == '0)
        else $error("rejected pixel with nonzero concentration");

    a_conc_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> concentration <= CONC_MAX)
        else $error("concentration above clamp");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> res_valid && res_stall)
        else $error("input stalled without a stalled output word");

endmodule

// File: bench/sea_ice_concentration_ratio_test.sv
// Testbench for the sea ice concentration pipeline: a scoreboard with random traffic and a pixel predictor.
`timescale 1ns / 1ps

module sea_ice_concentration_ratio_test;
    import sicr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 50;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [6:0]   conc;
        sicr_status_t st;
        logic         eoi;
    } pixel_word_t;

    logic clk;
    logic rst_n;
    logic pix_valid;
    logic pix_stall;
    logic [15:0] tb_19v;
    logic [15:0] tb_19h;
    logic [15:0] tb_37v;
    logic end_of_image;
    logic res_valid;
    logic res_stall;
    logic [6:0] concentration;
    logic [1:0] status;
    logic end_of_image_out;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    // shadow of the block's registers
    logic [47:0] floor_shadow;
    logic signed [15:0] wlim_shadow;
    longint coef_shadow [NUM_COEF];

    pixel_word_t expected_words [$];
    int errors;
    int cycles;
    int sent_count;
    int checked_count;
    int status_seen [4];
    int burst_left;
    bit hold_req;
    int hold_cnt;

    sea_ice_concentration_ratio DUT (
        .clk(clk),
        .rst_n(rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .tb_19v(tb_19v),
        .tb_19h(tb_19h),
        .tb_37v(tb_37v),
        .end_of_image(end_of_image),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .concentration(concentration),
        .status(status),
        .end_of_image_out(end_of_image_out),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint sat15(input longint v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    function automatic longint ratio15(input longint n, input longint d);
        longint mag;
        longint q;
        mag = (n < 0 ? -n : n) * 32768;
        q = (2 * mag + d) / (2 * d);
        return sat15(n < 0 ? -q : q);
    endfunction

    function automatic longint bilinear(input int base, input longint pr, input longint gr,
                                        input longint prgr);
        return coef_shadow[base] * 32768 + coef_shadow[base + 1] * pr +
               coef_shadow[base + 2] * gr + coef_shadow[base + 3] * prgr;
    endfunction

    function automatic longint percent_round(input longint num, input longint den);
        longint n;
        longint d;
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        n = 200 * num + den;
        d = 2 * den;
        if (n >= 0)
        begin
            return n / d;
        end
        return -((-n + d - 1) / d);
    endfunction

    function automatic pixel_word_t predict_pixel(input logic [15:0] v19, input logic [15:0] h19,
                                                  input logic [15:0] v37, input logic eoi);
        pixel_word_t w;
        longint gr;
        longint pr;
        longint p;
        longint mag;
        longint prgr;
        longint fy_num;
        longint den;
        longint my_num;
        longint fy;
        longint my;
        longint tot;
        w.conc = 7'd0;
        w.st = ST_VALID;
        w.eoi = eoi;
        if (v19 <= floor_shadow[15:0] || h19 <= floor_shadow[31:16] ||
            v37 <= floor_shadow[47:32])
        begin
            w.st = ST_FLOOR;
            return w;
        end
        gr = ratio15(longint'(v37) - longint'(v19), longint'(v37) + longint'(v19));
        if (gr > longint'(wlim_shadow))
        begin
            w.st = ST_WEATHER;
            return w;
        end
        pr = ratio15(longint'(v19) - longint'(h19), longint'(v19) + longint'(h19));
        p = pr * gr;
        mag = (p < 0) ? -p : p;
        mag = (mag + 16384) >>> 15;
        prgr = sat15(p < 0 ? -mag : mag);
        fy_num = bilinear(0, pr, gr, prgr);
        den = bilinear(4, pr, gr, prgr);
        my_num = bilinear(8, pr, gr, prgr);
        if (den == 0)
        begin
            w.st = ST_RANGE;
            return w;
        end
        fy = percent_round(fy_num, den);
        my = percent_round(my_num, den);
        tot = fy + my;
        if (fy < -20 || fy > 120 || my < -20 || my > 120 || tot < -20 || tot > 120)
        begin
            w.st = ST_RANGE;
        end
        else if (tot > 100)
        begin
            w.conc = CONC_MAX;
        end
        else if (tot > 0)
        begin
            w.conc = 7'(tot);
        end
        return w;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: run timed out with %0d words outstanding", $time,
                     expected_words.size());
            $display("sea_ice_concentration_ratio: mismatch");
            $finish;
        end
    end

    // receiver: a shifting stall pattern, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            res_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_req)
        begin
            res_stall <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            hold_req = 1'b0;
        end
        else
        begin
            case (cycles[9:8])
                2'd0: res_stall <= 1'b0;
                2'd1: res_stall <= ($urandom_range(0, 3) == 0);
                2'd2: res_stall <= ($urandom_range(0, 9) < 6);
                default: res_stall <= cycles[2];
            endcase
        end
    end

    always @(posedge clk)
    begin
        pixel_word_t w;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word conc=%0d status=%0d eoi=%0b", $time,
                         concentration, status, end_of_image_out);
            end
            else
            begin
                w = expected_words.pop_front();
                checked_count++;
                status_seen[w.st]++;
                if (concentration !== w.conc)
                begin
                    errors++;
                    $display("%0t: concentration expected %0d actual %0d", $time,
                             w.conc, concentration);
                end
                if (status !== w.st)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, w.st, status);
                end
                if (end_of_image_out !== w.eoi)
                begin
                    errors++;
                    $display("%0t: end_of_image_out expected %0b actual %0b", $time,
                             w.eoi, end_of_image_out);
                end
            end
        end
    end

    task automatic write_reg(input sicr_reg_idx_t idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 3;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FLOORS: floor_shadow = value[47:0];
            REG_WLIM: wlim_shadow = value[15:0];
            default:
            begin
                coef_shadow[2 * (int'(idx) - 2)] = longint'($signed(value[31:0]));
                coef_shadow[2 * (int'(idx) - 2) + 1] = longint'($signed(value[63:32]));
            end
        endcase
    endtask

    task automatic send_pixel(input logic [15:0] v19, input logic [15:0] h19,
                              input logic [15:0] v37, input logic eoi);
        pix_valid <= 1'b1;
        tb_19v <= v19;
        tb_19h <= h19;
        tb_37v <= v37;
        end_of_image <= eoi;
        do
        begin
            @(posedge clk);
        end
        while (pix_stall);
        expected_words.push_back(predict_pixel(v19, h19, v37, eoi));
        sent_count++;
    endtask

    // sender idling: bursts of random length with random gaps
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        pix_valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // mostly plausible ocean/ice temperatures, some fully random words
    task automatic send_random_pixel();
        logic [15:0] v19;
        logic [15:0] h19;
        logic [15:0] v37;
        if ($urandom_range(0, 6) == 0)
        begin
            v19 = $urandom;
            h19 = $urandom;
            v37 = $urandom;
        end
        else
        begin
            v19 = $urandom_range(17000, 27000);
            h19 = v19 - $urandom_range(200, 5000);
            v37 = v19 + $urandom_range(0, 5000) - 3000;
        end
        send_pixel(v19, h19, v37, $urandom_range(0, 15) == 0);
        pace_sender();
    endtask

    function automatic logic [31:0] q20(input int lo_milli, input int hi_milli);
        longint m;
        m = longint'(lo_milli) + longint'($urandom_range(0, hi_milli - lo_milli));
        return 32'((m * 1048576) / 1000);
    endfunction

    task automatic load_team_coefs();
        write_reg(REG_COEF_0_1, {q20(-3000, 3000), q20(-300, 1300)});
        write_reg(REG_COEF_2_3, {q20(-3000, 3000), q20(-3000, 3000)});
        write_reg(REG_COEF_4_5, {q20(-800, 800), q20(700, 1300)});
        write_reg(REG_COEF_6_7, {q20(-800, 800), q20(-800, 800)});
        write_reg(REG_COEF_8_9, {q20(-3000, 3000), q20(-300, 1000)});
        write_reg(REG_COEF_A_B, {q20(-3000, 3000), q20(-3000, 3000)});
    endtask

    // reset registers: everything that passes the checks has a zero denominator
    task automatic test_reset_defaults();
        send_pixel(16'd0, 16'd0, 16'd0, 1'b0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_pixel(16'd1, 16'd1, 16'd1, 1'b0);
        send_pixel(16'd20000, 16'd18000, 16'd21000, 1'b0);
        send_pixel(16'd20000, 16'd18000, 16'd23000, 1'b1);
        send_pixel(16'd1, 16'hFFFF, 16'hFFFF, 1'b0);
        send_pixel(16'hFFFF, 16'd1, 16'd1, 1'b0);
        drain();
    endtask

    task automatic test_floors_and_weather();
        write_reg(REG_FLOORS, {16'd15000, 16'd12000, 16'd16000});
        load_team_coefs();
        send_pixel(16'd16000, 16'd13000, 16'd20000, 1'b0);
        send_pixel(16'd16001, 16'd12000, 16'd20000, 1'b0);
        send_pixel(16'd16001, 16'd12001, 16'd15000, 1'b1);
        send_pixel(16'd16001, 16'd12001, 16'd15001, 1'b0);
        send_pixel(16'd20000, 16'd18000, 16'd22100, 1'b0);
        send_pixel(16'd20000, 16'd18000, 16'd22200, 1'b0);
        drain();
        write_reg(REG_WLIM, 16'h8000);
        write_reg(REG_FLOORS, 48'd0);
        send_pixel(16'd20000, 16'd18000, 16'd1, 1'b0);
        send_pixel(16'hFFFF, 16'd1, 16'd1, 1'b1);
        drain();
        write_reg(REG_WLIM, 16'h7FFF);
        send_pixel(16'd1, 16'hFFFF, 16'hFFFF, 1'b0);
        send_pixel(16'hFFFF, 16'd1, 16'd1, 1'b0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        drain();
        write_reg(REG_FLOORS, 48'hFFFF_FFFF_FFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        drain();
    endtask

    task automatic test_team_random();
        repeat (4)
        begin
            write_reg(REG_FLOORS, {16'($urandom_range(0, 15000)), 16'($urandom_range(0, 12000)),
                                   16'($urandom_range(0, 15000))});
            write_reg(REG_WLIM, 16'($urandom_range(0, 3000)));
            load_team_coefs();
            repeat (90) send_random_pixel();
            drain();
        end
    endtask

    task automatic test_extreme_coefs();
        write_reg(REG_FLOORS, 48'd0);
        write_reg(REG_WLIM, 16'h7FFF);
        write_reg(REG_COEF_0_1, 64'h8000_0000_7FFF_FFFF);
        write_reg(REG_COEF_2_3, 64'h7FFF_FFFF_8000_0000);
        write_reg(REG_COEF_4_5, 64'hFFFF_FFFF_0000_0001);
        write_reg(REG_COEF_6_7, 64'h0000_0001_FFFF_FFFF);
        write_reg(REG_COEF_8_9, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_COEF_A_B, 64'h8000_0000_8000_0000);
        repeat (30) send_random_pixel();
        drain();
        write_reg(REG_COEF_0_1, {$urandom, $urandom});
        write_reg(REG_COEF_2_3, {$urandom, $urandom});
        write_reg(REG_COEF_4_5, {$urandom, $urandom});
        write_reg(REG_COEF_6_7, {$urandom, $urandom});
        write_reg(REG_COEF_8_9, {$urandom, $urandom});
        write_reg(REG_COEF_A_B, {$urandom, $urandom});
        repeat (40) send_random_pixel();
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(REG_FLOORS, 48'd0);
        write_reg(REG_WLIM, 16'd1638);
        load_team_coefs();
        hold_req = 1'b1;
        repeat (80)
        begin
            send_random_pixel();
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        pix_valid <= 1'b0;
        tb_19v <= '0;
        tb_19h <= '0;
        tb_37v <= '0;
        end_of_image <= 1'b0;
        res_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        floor_shadow = '0;
        wlim_shadow = WLIM_RESET;
        foreach (coef_shadow[k])
        begin
            coef_shadow[k] = 0;
        end
        errors = 0;
        cycles = 0;
        sent_count = 0;
        checked_count = 0;
        status_seen = '{0, 0, 0, 0};
        burst_left = 0;
        hold_req = 1'b0;
        hold_cnt = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_reset_defaults();
        test_floors_and_weather();
        test_team_random();
        test_extreme_coefs();
        test_backpressure();
        $display("Covered %0d pixels, %0d words checked, %0d errors", sent_count,
                 checked_count, errors);
        $display("Status mix: valid %0d, floor %0d, weather %0d, range %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0)
        begin
            $display("sea_ice_concentration_ratio: match");
        end
        else
        begin
            $display("sea_ice_concentration_ratio: mismatch");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/sicr_pkg.sv
design/sicr_regs.sv
design/sicr_ratio.sv
design/sicr_forms.sv
design/sicr_percent.sv
design/sea_ice_concentration_ratio.sv
bench/sea_ice_concentration_ratio_test.sv
